// ----- hdl/txcw_pkg.sv -----
package txcw_pkg;

    // Field widths of the item ports
    localparam int MODE_W      = 2;
    localparam int CHAR_W      = 8;
    localparam int READ_ADDR_W = 11;
    localparam int CELL_W      = 16;
    localparam int CURSOR_COL_W = 7;
    localparam int CURSOR_ROW_W = 5;
    localparam int ATTR_W      = 8;

    // Default screen geometry
    localparam int DEFAULT_SCREEN_WIDTH  = 80;
    localparam int DEFAULT_SCREEN_HEIGHT = 25;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    // Character codes
    localparam logic [CHAR_W-1:0] CODE_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0] CODE_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CODE_BLANK   = 8'd32;

    localparam int TAB_STEP = 4;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd15;

endpackage

// ----- hdl/text_console_writer_unit.sv -----
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_stall  mode, char_code, read_address
// out      output     out_valid/out_stall cell_word, cursor_column, cursor_row
// cfg      input      cfg_write          cfg_data (text attribute)
//
// A plain put or a read is accepted, then makes one pass through the
// single write / single read port of the cell memory. A put that scrolls goes
// through accept, scroll check, a copy walk that moves every row but the first
// up by one row, blanking of the last row, then the put itself;
// a clear blanks every cell, one memory write per cycle.
// Reset clears cursor and sequencer and loads the default attribute; cell
// memory is not cleared. A result waiting on out_stall lets one more item in;
// that item then waits in its last state, so in_stall stays high until the
// output register frees.
module text_console_writer_unit #(
    parameter int SCREEN_WIDTH  = txcw_pkg::DEFAULT_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = txcw_pkg::DEFAULT_SCREEN_HEIGHT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [txcw_pkg::ATTR_W-1:0]        cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [txcw_pkg::MODE_W-1:0]        mode,
    input  logic [txcw_pkg::CHAR_W-1:0]        char_code,
    input  logic [txcw_pkg::READ_ADDR_W-1:0]   read_address,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [txcw_pkg::CELL_W-1:0]        cell_word,
    output logic [txcw_pkg::CURSOR_COL_W-1:0]  cursor_column,
    output logic [txcw_pkg::CURSOR_ROW_W-1:0]  cursor_row
);
    import txcw_pkg::*;

    localparam int CELL_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int COPY_COUNT = CELL_COUNT - SCREEN_WIDTH;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COL_W      = $clog2(SCREEN_WIDTH + 1);
    localparam int ROW_W      = $clog2(SCREEN_HEIGHT + 1);

    localparam logic [ADDR_W-1:0] SCR_W_A    = ADDR_W'(SCREEN_WIDTH);
    localparam logic [ADDR_W-1:0] COPY_END   = ADDR_W'(COPY_COUNT);
    localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELL_COUNT - 1);
    localparam logic [COL_W-1:0]  COL_LIMIT  = COL_W'(SCREEN_WIDTH);
    localparam logic [ROW_W-1:0]  ROW_LIMIT  = ROW_W'(SCREEN_HEIGHT);
    localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(SCREEN_HEIGHT - 1);

    // Sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PUT    = 3'd1;
    localparam logic [2:0] ST_SCROLL = 3'd2;
    localparam logic [2:0] ST_FILL   = 3'd3;
    localparam logic [2:0] ST_RDATA  = 3'd4;
    localparam logic [2:0] ST_REPORT = 3'd5;

    logic [CELL_W-1:0] screen_mem [CELL_COUNT];
    logic [CELL_W-1:0] rd_data_reg;

    logic [2:0]        state_reg, state_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic              fill_clear_reg, fill_clear_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              addr_ok_reg, addr_ok_next;
    logic [ATTR_W-1:0] attr_reg;

    logic              out_valid_reg, out_valid_next;
    logic [CELL_W-1:0] cell_word_reg, cell_word_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;

    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [CELL_W-1:0] mem_wdata;

    logic              out_free, out_load;
    logic [COL_W-1:0]  col_w;
    logic [ROW_W-1:0]  row_w;
    logic [CELL_W-1:0] blank_cell;
    logic [31:0]       rd_ext;
    logic              rd_ok;
    logic [31:0]       col_ext, row_ext;

    assign blank_cell = {attr_reg, CODE_BLANK};
    assign out_free   = !out_valid_reg || !out_stall;
    assign in_stall   = (state_reg != ST_IDLE);

    // Cursor after any pending wrap
    assign col_w = (col_reg == COL_LIMIT) ? '0 : col_reg;
    assign row_w = (col_reg == COL_LIMIT) ? row_reg + ROW_W'(1) : row_reg;

    // Read address check; out-of-range reads return zero
    assign rd_ext = 32'(read_address);
    assign rd_ok  = rd_ext < 32'(CELL_COUNT);

    // Sequencer and memory port control
    always_comb
    begin
        state_next      = state_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        ptr_next        = ptr_reg;
        fill_clear_next = fill_clear_reg;
        char_next       = char_reg;
        addr_ok_next    = addr_ok_reg;
        cell_word_next  = cell_word_reg;
        out_load        = 1'b0;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = ptr_reg;
        mem_raddr       = '0;
        mem_wdata       = blank_cell;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    char_next = char_code;
                    case (mode)
                        MODE_PUT:
                        begin
                            state_next = ST_PUT;
                        end
                        MODE_CLEAR:
                        begin
                            ptr_next        = '0;
                            fill_clear_next = 1'b1;
                            state_next      = ST_FILL;
                        end
                        MODE_READ:
                        begin
                            mem_re       = 1'b1;
                            mem_raddr    = rd_ok ? rd_ext[ADDR_W-1:0] : '0;
                            addr_ok_next = rd_ok;
                            state_next   = ST_RDATA;
                        end
                        default:
                        begin
                            state_next = ST_REPORT;
                        end
                    endcase
                end
            end

            ST_PUT:
            begin
                if (row_w == ROW_LIMIT)
                begin
                    // scroll first, then come back to handle the character
                    col_next        = col_w;
                    row_next        = ROW_LAST;
                    ptr_next        = '0;
                    fill_clear_next = 1'b0;
                    state_next      = ST_SCROLL;
                end
                else if (out_free)
                begin
                    out_load       = 1'b1;
                    cell_word_next = '0;
                    state_next     = ST_IDLE;
                    if (char_reg == CODE_NEWLINE)
                    begin
                        col_next = '0;
                        row_next = row_w + ROW_W'(1);
                    end
                    else if (char_reg == CODE_TAB)
                    begin
                        if ((COL_W+1)'(col_w) + (COL_W+1)'(TAB_STEP) <= (COL_W+1)'(COL_LIMIT))
                        begin
                            col_next = col_w + COL_W'(TAB_STEP);
                            row_next = row_w;
                        end
                        else
                        begin
                            col_next = '0;
                            row_next = row_w + ROW_W'(1);
                        end
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = ADDR_W'(row_w) * SCR_W_A + ADDR_W'(col_w);
                        mem_wdata = {attr_reg, char_reg};
                        col_next  = col_w + COL_W'(1);
                        row_next  = row_w;
                    end
                end
            end

            ST_SCROLL:
            begin
                // read one row ahead, write the word read last cycle
                if (ptr_reg != COPY_END)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_reg + SCR_W_A;
                end
                if (ptr_reg != '0)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = ptr_reg - ADDR_W'(1);
                    mem_wdata = rd_data_reg;
                end
                if (ptr_reg == COPY_END)
                    state_next = ST_FILL;
                else
                    ptr_next = ptr_reg + ADDR_W'(1);
            end

            ST_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = blank_cell;
                if (ptr_reg == LAST_CELL)
                begin
                    if (fill_clear_reg)
                    begin
                        col_next   = '0;
                        row_next   = '0;
                        state_next = ST_REPORT;
                    end
                    else
                        state_next = ST_PUT;
                end
                else
                    ptr_next = ptr_reg + ADDR_W'(1);
            end

            ST_RDATA:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    cell_word_next = addr_ok_reg ? rd_data_reg : '0;
                    state_next     = ST_IDLE;
                end
            end

            ST_REPORT:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    cell_word_next = '0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Output register
        out_col_next = out_load ? col_next : out_col_reg;
        out_row_next = out_load ? row_next : out_row_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            col_reg        <= '0;
            row_reg        <= '0;
            ptr_reg        <= '0;
            fill_clear_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            attr_reg       <= ATTR_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            ptr_reg        <= ptr_next;
            fill_clear_reg <= fill_clear_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_write)
                attr_reg <= cfg_data;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        char_reg      <= char_next;
        addr_ok_reg   <= addr_ok_next;
        cell_word_reg <= cell_word_next;
        out_col_reg   <= out_col_next;
        out_row_reg   <= out_row_next;
    end

    // Cell memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            screen_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= screen_mem[mem_raddr];
    end

    // Cursor fields masked to port widths
    assign col_ext = 32'(out_col_reg);
    assign row_ext = 32'(out_row_reg);

    assign out_valid     = out_valid_reg;
    assign cell_word     = cell_word_reg;
    assign cursor_column = col_ext[CURSOR_COL_W-1:0];
    assign cursor_row    = row_ext[CURSOR_ROW_W-1:0];

endmodule
